>>> rtl/crc16fd_pkg.sv
package crc16fd_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 1024;

    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [16:0] MIN_FRAME = 17'd11;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP = 16'h8000;

    localparam int TDATA_W = 88;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_CRC    = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_START_BYTE = 1'b0,
        CFG_END_BYTE   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic       wr_en;
        cfg_index_t index;
        logic [7:0] data;
    } cfg_write_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        status_t     status;
        logic [7:0]  command;
        logic [15:0] length;
        logic [31:0] seq_num;
        logic [15:0] rx_crc;
    } result_t;

    // CCITT byte update, MSB first, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/crc16fd_in_reg.sv
module crc16fd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       advance,
    output logic       valid,
    output logic [7:0] data_byte,
    output logic       last_byte
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready  = !valid_reg || advance;
    assign valid     = valid_reg;
    assign data_byte = data_reg;
    assign last_byte = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

endmodule

>>> rtl/crc16fd_parser.sv
module crc16fd_parser #(
    parameter int MAX_PAYLOAD = crc16fd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crc16fd_pkg::cfg_write_t cfg,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 res_valid,
    output crc16fd_pkg::result_t res
);
    import crc16fd_pkg::*;

    localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

    logic [7:0]       start_byte_reg;
    logic [7:0]       end_byte_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [15:0]      len_reg, len_next;
    logic [31:0]      seq_reg, seq_next;
    logic [15:0]      rxcrc_reg, rxcrc_next;
    logic             fbad_reg, fbad_next;

    logic [16:0] pos17;
    logic [16:0] len17;
    logic [16:0] count;
    logic        emit;
    logic        bad;

    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        rxcrc_next = rxcrc_reg;
        fbad_next  = fbad_reg;
        emit       = 1'b0;
        bad        = 1'b0;
        pos17      = {6'b0, pos_reg};
        len17      = {1'b0, len_reg};
        count      = pos17 + 17'd1;

        if (pos_reg == POS_MAX) begin
            fbad_next = 1'b1;
        end

        if (pos_reg == '0) begin
            if (data_byte != start_byte_reg) begin
                fbad_next = 1'b1;
            end
        end else if (pos17 < 17'd8) begin
            crc_next = crc_feed(crc_reg, data_byte);
            case (pos_reg[2:0])
                3'd1: cmd_next = data_byte;
                3'd2: len_next[7:0] = data_byte;
                3'd3: len_next[15:8] = data_byte;
                3'd4, 3'd5, 3'd6, 3'd7: seq_next[{pos_reg[1:0], 3'b000} +: 8] = data_byte;
                default: ;
            endcase
        end else if (pos17 < len17 + 17'd8) begin
            crc_next = crc_feed(crc_reg, data_byte);
            emit     = (len17 <= MaxLen);
        end else if (pos17 == len17 + 17'd8) begin
            rxcrc_next[7:0] = data_byte;
        end else if (pos17 == len17 + 17'd9) begin
            rxcrc_next[15:8] = data_byte;
        end

        if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end

        res.kind     = KIND_PAYLOAD;
        res.payload  = data_byte;
        res.status   = STATUS_OK;
        res.command  = '0;
        res.length   = '0;
        res.seq_num  = '0;
        res.rx_crc   = '0;
        res_valid    = emit;

        if (last_byte) begin
            // status reflects the closing byte's placement
            bad = fbad_next
                || (count < MIN_FRAME)
                || (data_byte != end_byte_reg)
                || ({1'b0, len_next} > MaxLen)
                || (count != {1'b0, len_next} + MIN_FRAME);
            res_valid    = 1'b1;
            res.kind     = KIND_STATUS;
            res.payload  = '0;
            res.command  = cmd_next;
            res.length   = len_next;
            res.seq_num  = seq_next;
            res.rx_crc   = rxcrc_next;
            if (bad) begin
                res.status = STATUS_FORMAT;
            end else if (rxcrc_next != crc_next) begin
                res.status = STATUS_CRC;
            end else begin
                res.status = STATUS_OK;
            end

            pos_next   = '0;
            crc_next   = CRC_INIT;
            cmd_next   = '0;
            len_next   = '0;
            seq_next   = '0;
            rxcrc_next = '0;
            fbad_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= '0;
            end_byte_reg   <= '0;
        end else if (cfg.wr_en) begin
            case (cfg.index)
                CFG_START_BYTE: start_byte_reg <= cfg.data;
                CFG_END_BYTE:   end_byte_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            rxcrc_reg <= '0;
            fbad_reg  <= 1'b0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            rxcrc_reg <= rxcrc_next;
            fbad_reg  <= fbad_next;
        end
    end

endmodule

>>> rtl/crc16fd_out_reg.sv
module crc16fd_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 res_valid,
    input  crc16fd_pkg::result_t res,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output crc16fd_pkg::result_t m_res
);
    import crc16fd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // stage moves when an input byte is held and the result slot is free or being emptied this cycle
    assign advance  = in_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> rtl/crc16_frame_deframer_unit.sv
// A result is registered after its byte has passed the input register; one byte
// per cycle unless m_tready stalls the result register. The CRC byte update is
// combinational XOR logic between the input register and the result register.
// Payload bytes give one result when length <= MAX_PAYLOAD, the last byte one
// status result, others none. Reset (aresetn low, synchronous) empties both
// registers, zeroes the delimiter registers, returns frame state to its start.
module crc16_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = crc16fd_pkg::DEFAULT_MAX_PAYLOAD
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // payload_byte, status_code, command_code, length_field, sequence_number,
    // received_crc, zero pad
    output logic [crc16fd_pkg::TDATA_W-1:0] m_tdata,
    output logic                             m_tuser    // item_kind
);
    import crc16fd_pkg::*;

    cfg_write_t cfg;
    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_data;

    crc16fd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .advance   (advance),
        .valid     (in_valid),
        .data_byte (in_byte),
        .last_byte (in_last)
    );

    crc16fd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (advance),
        .data_byte (in_byte),
        .last_byte (in_last),
        .res_valid (res_valid),
        .res       (res)
    );

    crc16fd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tuser = m_res.kind;
    assign m_tdata = {6'b0, m_res.rx_crc, m_res.seq_num, m_res.length,
                      m_res.command, m_res.status, m_res.payload};

endmodule
